[hw/rtl/homopolymer_run_compressor_macros.svh]
// ----------------------------------------------------------------------------
// homopolymer run compressor assertion macros
// concurrent assertion helpers shared by the rtl files that check themselves
// ----------------------------------------------------------------------------
`ifndef HOMOPOLYMER_RUN_COMPRESSOR_MACROS_SVH
`define HOMOPOLYMER_RUN_COMPRESSOR_MACROS_SVH

// same-cycle implication
`define HRC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define HRC_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

[hw/rtl/hrc_pkg.sv]
// ----------------------------------------------------------------------------
// hrc_pkg
// shared widths, types and codes of the homopolymer run compressor
// ----------------------------------------------------------------------------
package hrc_pkg;

	localparam int MAX_READ_LENGTH    = 4096;
	localparam int QUAL_FRACTION_BITS = 8;

	localparam int BASE_W  = 8;
	localparam int QUAL_W  = 7;
	localparam int POS_W   = 12;
	localparam int LEN_W   = 13;
	localparam int SUM_W   = 19;
	localparam int MEAN_W  = 15;

	localparam int DIV_W   = SUM_W + QUAL_FRACTION_BITS;
	localparam int QUOT_W  = QUAL_W + QUAL_FRACTION_BITS;
	localparam int REM_W   = LEN_W;
	localparam int STEP_W  = $clog2(QUOT_W);

	localparam int FIFO_DEPTH = 4;
	localparam int PTR_W      = $clog2(FIFO_DEPTH);
	localparam int CNT_W      = PTR_W + 1;

	typedef logic [BASE_W-1:0] base_t;
	typedef logic [QUAL_W-1:0] qual_t;
	typedef logic [POS_W-1:0]  pos_t;
	typedef logic [LEN_W-1:0]  len_t;
	typedef logic [SUM_W-1:0]  sum_t;
	typedef logic [MEAN_W-1:0] mean_t;
	typedef logic [DIV_W-1:0]  div_t;
	typedef logic [QUOT_W-1:0] quot_t;
	typedef logic [REM_W-1:0]  rem_t;
	typedef logic [STEP_W-1:0] step_t;
	typedef logic [PTR_W-1:0]  ptr_t;
	typedef logic [CNT_W-1:0]  cnt_t;

	localparam len_t MAX_LEN  = len_t'(MAX_READ_LENGTH);
	localparam pos_t MAX_POS  = pos_t'(MAX_READ_LENGTH - 1);
	localparam step_t LAST_STEP = step_t'(QUOT_W - 1);

	// one closed run on its way to the divider
	typedef struct packed {
		base_t letter;
		sum_t  sum;
		pos_t  start;
		len_t  length;
		logic  mate;
		logic  final_run;
		logic  last;
		logic  ovf;
	} run_rec_t;

	typedef struct packed {
		logic full;
		logic empty;
	} fifo_stat_t;

	typedef struct packed {
		base_t letter;
		mean_t mean;
		pos_t  start;
		len_t  length;
		logic  mate;
		logic  final_run;
		logic  last;
		logic  ovf;
	} result_t;

	typedef enum logic [1:0] {
		BK_IDLE,
		BK_DIV,
		BK_DONE
	} back_state_t;

endpackage

[hw/rtl/hrc_front.sv]
// ----------------------------------------------------------------------------
// hrc_front
// run detection: tracks the open run and read position, emits closed runs
// ----------------------------------------------------------------------------
module hrc_front (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  hrc_pkg::base_t      base,
	input  hrc_pkg::qual_t      quality,
	input  logic                end_of_read,
	input  hrc_pkg::fifo_stat_t q_stat,
	output logic                q_push,
	output hrc_pkg::run_rec_t   q_rec
);

	logic            open_q;
	hrc_pkg::base_t  base_q;
	hrc_pkg::pos_t   begin_q;
	hrc_pkg::len_t   count_q;
	hrc_pkg::sum_t   sum_q;
	hrc_pkg::len_t   rp_q;
	logic            mate_q;
	logic            ovf_q;

	logic              pend_q;
	hrc_pkg::run_rec_t pend_rec_q;

	logic            open_n;
	hrc_pkg::base_t  base_n;
	hrc_pkg::pos_t   begin_n;
	hrc_pkg::len_t   count_n;
	hrc_pkg::sum_t   sum_n;
	hrc_pkg::len_t   rp_n;
	logic            mate_n;
	logic            ovf_n;
	logic            ovf_emit;

	hrc_pkg::pos_t     pos;
	logic              same;
	logic              emit_a;
	logic              accept;
	hrc_pkg::run_rec_t rec_a;
	hrc_pkg::run_rec_t rec_b;

	assign full   = pend_q | q_stat.full;
	assign accept = push & ~full;

	always_comb begin
		rp_n     = rp_q;
		ovf_emit = ovf_q;
		pos      = rp_q[hrc_pkg::POS_W-1:0];
		if (rp_q < hrc_pkg::MAX_LEN) begin
			rp_n = rp_q + hrc_pkg::len_t'(1);
		end else begin
			ovf_emit = 1'b1;
			pos      = hrc_pkg::MAX_POS;
		end

		same   = open_q & (base == base_q);
		emit_a = open_q & ~same;

		rec_a.letter    = base_q;
		rec_a.sum       = sum_q;
		rec_a.start     = begin_q;
		rec_a.length    = count_q;
		rec_a.mate      = mate_q;
		rec_a.final_run = 1'b0;
		rec_a.last      = ~end_of_read;
		rec_a.ovf       = ovf_emit;

		open_n  = 1'b1;
		base_n  = base_q;
		begin_n = begin_q;
		count_n = count_q;
		sum_n   = sum_q;
		if (same) begin
			if (count_q < hrc_pkg::MAX_LEN) begin
				count_n = count_q + hrc_pkg::len_t'(1);
				sum_n   = sum_q + hrc_pkg::sum_t'(quality);
			end
		end else begin
			base_n  = base;
			begin_n = pos;
			count_n = hrc_pkg::len_t'(1);
			sum_n   = hrc_pkg::sum_t'(quality);
		end

		rec_b.letter    = base_n;
		rec_b.sum       = sum_n;
		rec_b.start     = begin_n;
		rec_b.length    = count_n;
		rec_b.mate      = mate_q;
		rec_b.final_run = 1'b1;
		rec_b.last      = 1'b1;
		rec_b.ovf       = ovf_emit;

		ovf_n  = ovf_emit;
		mate_n = mate_q;
		if (end_of_read) begin
			open_n  = 1'b0;
			base_n  = '0;
			begin_n = '0;
			count_n = '0;
			sum_n   = '0;
			rp_n    = '0;
			ovf_n   = 1'b0;
			mate_n  = ~mate_q;
		end
	end

	always_comb begin
		if (pend_q) begin
			q_push = ~q_stat.full;
			q_rec  = pend_rec_q;
		end else begin
			q_push = accept & (emit_a | end_of_read);
			q_rec  = emit_a ? rec_a : rec_b;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q  <= 1'b0;
			base_q  <= '0;
			begin_q <= '0;
			count_q <= '0;
			sum_q   <= '0;
			rp_q    <= '0;
			mate_q  <= 1'b0;
			ovf_q   <= 1'b0;
			pend_q  <= 1'b0;
		end else begin
			if (accept) begin
				open_q  <= open_n;
				base_q  <= base_n;
				begin_q <= begin_n;
				count_q <= count_n;
				sum_q   <= sum_n;
				rp_q    <= rp_n;
				mate_q  <= mate_n;
				ovf_q   <= ovf_n;
			end
			// second run of a beat waits here for a free queue slot
			if (accept & emit_a & end_of_read) begin
				pend_q <= 1'b1;
			end else if (pend_q & ~q_stat.full) begin
				pend_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept & emit_a & end_of_read) begin
			pend_rec_q <= rec_b;
		end
	end

endmodule

[hw/rtl/hrc_fifo.sv]
// ----------------------------------------------------------------------------
// hrc_fifo
// short run queue between run detection and the mean divider
// ----------------------------------------------------------------------------
module hrc_fifo (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  hrc_pkg::run_rec_t   wr_rec,
	input  logic                rd_en,
	output hrc_pkg::run_rec_t   rd_rec,
	output hrc_pkg::fifo_stat_t stat
);

	hrc_pkg::run_rec_t mem_q [hrc_pkg::FIFO_DEPTH];
	hrc_pkg::ptr_t     wr_ptr_q;
	hrc_pkg::ptr_t     rd_ptr_q;
	hrc_pkg::cnt_t     cnt_q;

	assign stat.full  = (cnt_q == hrc_pkg::cnt_t'(hrc_pkg::FIFO_DEPTH));
	assign stat.empty = (cnt_q == '0);
	assign rd_rec     = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (wr_en) begin
				wr_ptr_q <= wr_ptr_q + hrc_pkg::ptr_t'(1);
			end
			if (rd_en) begin
				rd_ptr_q <= rd_ptr_q + hrc_pkg::ptr_t'(1);
			end
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + hrc_pkg::cnt_t'(1);
				2'b01:   cnt_q <= cnt_q - hrc_pkg::cnt_t'(1);
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_ptr_q] <= wr_rec;
		end
	end

endmodule

[hw/rtl/hrc_back.sv]
// ----------------------------------------------------------------------------
// hrc_back
// mean quality divider, one quotient bit a cycle, and the result register
// ----------------------------------------------------------------------------
module hrc_back (
	input  logic                clk,
	input  logic                arst_n,
	input  hrc_pkg::run_rec_t   q_rec,
	input  hrc_pkg::fifo_stat_t q_stat,
	output logic                q_pop,
	input  logic                pop,
	output logic                empty,
	output hrc_pkg::result_t    res
);

	hrc_pkg::back_state_t state_q;
	hrc_pkg::back_state_t state_n;

	hrc_pkg::run_rec_t rec_q;
	hrc_pkg::rem_t     rem_q;
	hrc_pkg::quot_t    quo_q;
	hrc_pkg::step_t    step_q;
	logic              out_valid_q;
	hrc_pkg::result_t  out_q;

	logic               ld;
	logic               step;
	logic               out_load;
	logic               out_free;
	hrc_pkg::div_t      dividend;
	logic [hrc_pkg::REM_W:0] rem_sh;
	logic [hrc_pkg::REM_W:0] diff;
	logic               ge;

	assign out_free = ~out_valid_q | pop;
	assign dividend = {q_rec.sum, {hrc_pkg::QUAL_FRACTION_BITS{1'b0}}};
	assign rem_sh   = {rem_q, quo_q[hrc_pkg::QUOT_W-1]};
	assign ge       = (rem_sh >= {1'b0, rec_q.length});
	assign diff     = rem_sh - {1'b0, rec_q.length};

	always_comb begin
		state_n = state_q;
		case (state_q)
			hrc_pkg::BK_IDLE: begin
				if (!q_stat.empty) state_n = hrc_pkg::BK_DIV;
			end
			hrc_pkg::BK_DIV: begin
				if (step_q == hrc_pkg::LAST_STEP) state_n = hrc_pkg::BK_DONE;
			end
			hrc_pkg::BK_DONE: begin
				if (out_free) state_n = hrc_pkg::BK_IDLE;
			end
			default: state_n = hrc_pkg::BK_IDLE;
		endcase
	end

	always_comb begin
		ld       = 1'b0;
		step     = 1'b0;
		out_load = 1'b0;
		case (state_q)
			hrc_pkg::BK_IDLE: ld       = ~q_stat.empty;
			hrc_pkg::BK_DIV:  step     = 1'b1;
			hrc_pkg::BK_DONE: out_load = out_free;
			default: ;
		endcase
	end

	assign q_pop = ld;
	assign empty = ~out_valid_q;
	assign res   = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= hrc_pkg::BK_IDLE;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (ld) begin
				step_q <= '0;
			end else if (step) begin
				step_q <= step_q + hrc_pkg::step_t'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// high dividend bits start as the remainder, always below the run length
	always_ff @(posedge clk) begin
		if (ld) begin
			rec_q <= q_rec;
			rem_q <= hrc_pkg::rem_t'(dividend[hrc_pkg::DIV_W-1:hrc_pkg::QUOT_W]);
			quo_q <= dividend[hrc_pkg::QUOT_W-1:0];
		end else if (step) begin
			rem_q <= ge ? diff[hrc_pkg::REM_W-1:0] : rem_sh[hrc_pkg::REM_W-1:0];
			quo_q <= {quo_q[hrc_pkg::QUOT_W-2:0], ge};
		end
		if (out_load) begin
			out_q.letter    <= rec_q.letter;
			out_q.mean      <= quo_q[hrc_pkg::MEAN_W-1:0];
			out_q.start     <= rec_q.start;
			out_q.length    <= rec_q.length;
			out_q.mate      <= rec_q.mate;
			out_q.final_run <= rec_q.final_run;
			out_q.last      <= rec_q.last;
			out_q.ovf       <= rec_q.ovf;
		end
	end

endmodule

[hw/rtl/homopolymer_run_compressor.sv]
// ----------------------------------------------------------------------------
// homopolymer_run_compressor
// Takes one base a beat and emits one beat per closed homopolymer run. The
// input side accepts a base every cycle while the four-entry run queue has
// room; a beat that closes two runs (a base change and the end of its read)
// holds full until its second run has a free queue slot. Each run then goes
// through the mean quality divider, which produces one quotient bit a cycle
// and takes the next run from the queue only once it is done with the previous
// one, and bases that extend an open run cost no divider time. Results wait in
// an output register while the divider works on the next run.
// ----------------------------------------------------------------------------
`include "homopolymer_run_compressor_macros.svh"

module homopolymer_run_compressor (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	output logic                 full,
	input  hrc_pkg::base_t       base,
	input  hrc_pkg::qual_t       quality,
	input  logic                 end_of_read,
	output logic                 empty,
	input  logic                 pop,
	output hrc_pkg::base_t       run_letter,
	output hrc_pkg::mean_t       mean_quality,
	output hrc_pkg::pos_t        run_start,
	output hrc_pkg::len_t        run_length,
	output logic                 from_mate,
	output logic                 final_run,
	output logic                 last_of_item,
	output logic                 overflow
);

	logic                q_push;
	logic                q_pop;
	hrc_pkg::run_rec_t   wr_rec;
	hrc_pkg::run_rec_t   rd_rec;
	hrc_pkg::fifo_stat_t q_stat;
	hrc_pkg::result_t    res;

	hrc_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.base        (base),
		.quality     (quality),
		.end_of_read (end_of_read),
		.q_stat      (q_stat),
		.q_push      (q_push),
		.q_rec       (wr_rec)
	);

	hrc_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.wr_en  (q_push),
		.wr_rec (wr_rec),
		.rd_en  (q_pop),
		.rd_rec (rd_rec),
		.stat   (q_stat)
	);

	hrc_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.q_rec  (rd_rec),
		.q_stat (q_stat),
		.q_pop  (q_pop),
		.pop    (pop),
		.empty  (empty),
		.res    (res)
	);

	assign run_letter   = res.letter;
	assign mean_quality = res.mean;
	assign run_start    = res.start;
	assign run_length   = res.length;
	assign from_mate    = res.mate;
	assign final_run    = res.final_run;
	assign last_of_item = res.last;
	assign overflow     = res.ovf;

	`HRC_ASSERT_IMPL(a_queue_no_overrun, clk, arst_n, q_push, !q_stat.full)
	`HRC_ASSERT_IMPL(a_queue_no_underrun, clk, arst_n, q_pop, !q_stat.empty)
	`HRC_ASSERT_NEXT(a_double_run_blocks, clk, arst_n, push && !full && end_of_read && q_push && !wr_rec.final_run, full)
	`HRC_ASSERT_IMPL(a_result_has_length, clk, arst_n, !empty, run_length != '0)

endmodule
